// ----- rtl/vna_pkg.sv -----
// Shared types and constants for the vertex normal accumulator.
package vna_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int ACCUM_BITS_DEF   = 48;
	localparam int IDX_W            = 10;
	localparam int POS_W            = 16;
	localparam int NRM_W            = 16;
	localparam int CROSS_W          = 36;
	localparam int NORM_LIM         = 30;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_TRI  = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TRI_RD,
		ST_TRI_WAIT,
		ST_EDGE,
		ST_MUL,
		ST_CROSS,
		ST_ACC_RD,
		ST_ACC_WAIT,
		ST_ACC_WR,
		ST_RD_WAIT,
		ST_RD_MAG,
		ST_SHIFT,
		ST_SQ,
		ST_SUM,
		ST_SQRT,
		ST_DIV_START,
		ST_DIV,
		ST_DIV_NEXT,
		ST_OUT
	} state_t;

endpackage

// ----- rtl/vna_if.sv -----
// Valid/ready channel interfaces for the command and normal beats.
interface vna_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [vna_pkg::IDX_W-1:0] vertex_index;
	logic signed [vna_pkg::POS_W-1:0] pos_x;
	logic signed [vna_pkg::POS_W-1:0] pos_y;
	logic signed [vna_pkg::POS_W-1:0] pos_z;
	logic [vna_pkg::IDX_W-1:0] corner_a;
	logic [vna_pkg::IDX_W-1:0] corner_b;
	logic [vna_pkg::IDX_W-1:0] corner_c;
	modport source (output valid, cmd, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, input ready);
	modport sink (input valid, cmd, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, output ready);
endinterface

interface vna_nrm_if;
	logic        valid;
	logic        ready;
	logic [vna_pkg::IDX_W-1:0] out_index;
	logic signed [vna_pkg::NRM_W-1:0] normal_x;
	logic signed [vna_pkg::NRM_W-1:0] normal_y;
	logic signed [vna_pkg::NRM_W-1:0] normal_z;
	logic        degenerate;
	modport source (output valid, out_index, normal_x, normal_y, normal_z, degenerate,
		input ready);
	modport sink (input valid, out_index, normal_x, normal_y, normal_z, degenerate,
		output ready);
endinterface

// ----- rtl/vna_isqrt.sv -----
// Iterative integer square root, one root bit per cycle from two radicand bits.
module vna_isqrt #(
	parameter int IN_W = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [IN_W-1:0]   radicand,
	output logic              done,
	output logic [IN_W/2-1:0] root
);
	localparam int STEPS = IN_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [IN_W-1:0]   x_q;
	logic [IN_W/2+1:0] rem_q;
	logic [IN_W/2-1:0] r_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [IN_W/2+1:0] rem_sh;
	logic [IN_W/2+1:0] trial;

	// restoring digit recurrence: bring down two bits, test 4r+1
	assign rem_sh = {rem_q[IN_W/2-1:0], x_q[IN_W-1 -: 2]};
	assign trial  = {r_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= busy_q && !start && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			rem_q <= '0;
			r_q   <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[IN_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				r_q   <= {r_q[IN_W/2-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				r_q   <= {r_q[IN_W/2-2:0], 1'b0};
			end
		end
	end

	assign root = r_q;
endmodule

// ----- rtl/vna_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module vna_div #(
	parameter int NUM_W = 46,
	parameter int DEN_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic              done,
	output logic [NUM_W-1:0]  quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] n_q;
	logic [DEN_W-1:0] d_q;
	logic [DEN_W:0]   rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   rem_sh;

	assign rem_sh = {rem_q[DEN_W-1:0], n_q[NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= busy_q && !start && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, d_q}) begin
				rem_q <= rem_sh - {1'b0, d_q};
				n_q   <= {n_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				n_q   <= {n_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quo = n_q;
endmodule

// ----- rtl/vertex_normal_accumulator_top.sv -----
// Area-weighted vertex normal accumulator: stores, sequencer and normalizer.
//
// Channels: cmd_in (sink) takes one command beat; nrm_out (source) gives one
// beat for each read command. Load and triangle commands give no beat.
// A load writes the position and accumulator memories at its accepting edge;
// the next command can be taken in the following cycle.
// A triangle reads the three corner positions through one memory port, forms the
// cross product, then does a read-modify-write of the accumulator memory for
// each corner. Repeated corners are handled since each corner's update completes
// before the next is read.
// A read shifts the components until the peak fits, then runs the square root
// and three serial divisions; a zero normal skips these and gives a degenerate
// beat. After reset a clearing pass walks the accumulator memory, one vertex per
// cycle, while cmd_in.ready stays low.
// The result register holds a normal beat until taken; the next command is
// accepted only after the previous one is finished, so a stalled receiver
// stalls the command side only once a read result is pending.
module vertex_normal_accumulator_top #(
	parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
	parameter int ACCUM_BITS   = vna_pkg::ACCUM_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	vna_cmd_if.sink  cmd_in,
	vna_nrm_if.source nrm_out
);
	localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int IW    = vna_pkg::IDX_W;
	localparam int PW    = vna_pkg::POS_W;
	localparam int EW    = PW + 1;
	localparam int PRW   = 2 * EW;
	localparam int CW    = vna_pkg::CROSS_W;
	localparam int AB    = ACCUM_BITS;
	localparam int LIM   = vna_pkg::NORM_LIM;
	localparam int SQW   = 2 * LIM;
	localparam int SUMW  = SQW + 2;
	localparam int RW    = SUMW / 2;
	localparam int NUMW  = LIM + 15;
	localparam int SHW   = $clog2(AB + 1);
	localparam int CLRW  = AW + 1;

	// memories
	logic [3*PW-1:0] pos_mem [MAX_VERTICES];
	logic [3*AB-1:0] acc_mem [MAX_VERTICES];

	vna_pkg::state_t state_q, state_d;

	logic [CLRW-1:0] clr_q;
	logic            clr_busy;
	logic [1:0]      k_q;
	logic [IW-1:0]   idx_q;
	logic [IW-1:0]   ca_q, cb_q, cc_q;
	logic [AW-1:0]   pos_raddr, acc_addr;
	logic [3*PW-1:0] pos_rdata_q;
	logic [3*AB-1:0] acc_rdata_q;
	logic            acc_we;
	logic [3*AB-1:0] acc_wdata;
	logic            pos_we;

	logic signed [PW-1:0]  pa_q [3];
	logic signed [PW-1:0]  pb_q [3];
	logic signed [EW-1:0]  e1_q [3];
	logic signed [EW-1:0]  e2_q [3];
	logic signed [PRW-1:0] pr_q [6];
	logic signed [CW-1:0]  n_q  [3];

	logic signed [AB-1:0] a_q [3];
	logic [AB-1:0]        m_q [3];
	logic [SHW-1:0]       s_q;
	logic [LIM-1:0]       b_q [3];
	logic [SQW-1:0]       sq_q [3];
	logic [SUMW-1:0]      sum_sq;
	logic [RW-1:0]        len_q;
	logic signed [vna_pkg::NRM_W-1:0] res_q [3];
	logic                 deg_q;
	logic                 ovalid_q;

	logic            sq_start, sq_done, dv_start, dv_done;
	logic [RW-1:0]   sq_root;
	logic [NUMW-1:0] dv_num, dv_quo;
	logic [AB-1:0]   mx;
	logic            accept;
	logic            in_range_tri;

	assign clr_busy = !clr_q[AW] && (clr_q[AW-1:0] <= AW'(MAX_VERTICES - 1));
	assign accept   = cmd_in.valid && cmd_in.ready;
	assign cmd_in.ready = (state_q == vna_pkg::ST_IDLE) && !clr_busy && !ovalid_q;
	assign in_range_tri = (32'(cmd_in.corner_a) < MAX_VERTICES)
		&& (32'(cmd_in.corner_b) < MAX_VERTICES) && (32'(cmd_in.corner_c) < MAX_VERTICES);

	function automatic logic [IW-1:0] corner_sel(input logic [1:0] k,
		input logic [IW-1:0] a, input logic [IW-1:0] b, input logic [IW-1:0] c);
		logic [IW-1:0] r;
		unique case (k)
			2'd0:    r = a;
			2'd1:    r = b;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic logic signed [AB-1:0] sat_add(input logic signed [AB-1:0] acc,
		input logic signed [CW-1:0] n);
		logic signed [AB:0] s;
		s = {acc[AB-1], acc} + (AB+1)'(n);
		if (s[AB] != s[AB-1])
			return s[AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
		return s[AB-1:0];
	endfunction

	function automatic logic [AB-1:0] magn(input logic signed [AB-1:0] v);
		return v[AB-1] ? (AB'(0) - AB'(v)) : AB'(v);
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vna_pkg::ST_IDLE: begin
				if (accept) begin
					priority case (cmd_in.cmd)
						vna_pkg::CMD_LOAD: state_d = vna_pkg::ST_IDLE;
						vna_pkg::CMD_TRI:  state_d = in_range_tri ? vna_pkg::ST_TRI_RD
							: vna_pkg::ST_IDLE;
						vna_pkg::CMD_READ: state_d = (32'(cmd_in.vertex_index) < MAX_VERTICES)
							? vna_pkg::ST_RD_WAIT : vna_pkg::ST_OUT;
						default:           state_d = vna_pkg::ST_IDLE;
					endcase
				end
			end
			vna_pkg::ST_TRI_RD:   state_d = vna_pkg::ST_TRI_WAIT;
			vna_pkg::ST_TRI_WAIT: state_d = (k_q == 2'd2) ? vna_pkg::ST_EDGE
				: vna_pkg::ST_TRI_RD;
			vna_pkg::ST_EDGE:     state_d = vna_pkg::ST_MUL;
			vna_pkg::ST_MUL:      state_d = vna_pkg::ST_CROSS;
			vna_pkg::ST_CROSS:    state_d = vna_pkg::ST_ACC_RD;
			vna_pkg::ST_ACC_RD:   state_d = vna_pkg::ST_ACC_WAIT;
			vna_pkg::ST_ACC_WAIT: state_d = vna_pkg::ST_ACC_WR;
			vna_pkg::ST_ACC_WR:   state_d = (k_q == 2'd2) ? vna_pkg::ST_IDLE
				: vna_pkg::ST_ACC_RD;
			vna_pkg::ST_RD_WAIT:  state_d = vna_pkg::ST_RD_MAG;
			vna_pkg::ST_RD_MAG:   state_d = vna_pkg::ST_SHIFT;
			vna_pkg::ST_SHIFT: begin
				if (mx == '0)
					state_d = vna_pkg::ST_OUT;
				else if ((mx >> s_q) < (AB'(1) << LIM))
					state_d = vna_pkg::ST_SQ;
			end
			vna_pkg::ST_SQ:       state_d = vna_pkg::ST_SUM;
			vna_pkg::ST_SUM:      state_d = vna_pkg::ST_SQRT;
			vna_pkg::ST_SQRT:     state_d = sq_done ? vna_pkg::ST_DIV_START : vna_pkg::ST_SQRT;
			vna_pkg::ST_DIV_START: state_d = vna_pkg::ST_DIV;
			vna_pkg::ST_DIV:      state_d = dv_done ? vna_pkg::ST_DIV_NEXT : vna_pkg::ST_DIV;
			vna_pkg::ST_DIV_NEXT: state_d = (k_q == 2'd2) ? vna_pkg::ST_OUT
				: vna_pkg::ST_DIV_START;
			vna_pkg::ST_OUT:      state_d = vna_pkg::ST_IDLE;
			default:              state_d = vna_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pos_we    = 1'b0;
		acc_we    = 1'b0;
		acc_wdata = '0;
		pos_raddr = AW'(corner_sel(k_q, ca_q, cb_q, cc_q));
		acc_addr  = AW'(corner_sel(k_q, ca_q, cb_q, cc_q));
		sq_start  = 1'b0;
		dv_start  = 1'b0;
		unique case (state_q)
			vna_pkg::ST_IDLE: begin
				acc_addr = AW'(cmd_in.vertex_index);
				if (clr_busy) begin
					acc_we   = 1'b1;
					acc_addr = clr_q[AW-1:0];
				end else if (accept && cmd_in.cmd == vna_pkg::CMD_LOAD
					&& 32'(cmd_in.vertex_index) < MAX_VERTICES) begin
					pos_we = 1'b1;
					acc_we = 1'b1;
				end
			end
			vna_pkg::ST_ACC_WR: begin
				acc_we    = 1'b1;
				acc_wdata = {sat_add(acc_rdata_q[3*AB-1 -: AB], n_q[0]),
					sat_add(acc_rdata_q[2*AB-1 -: AB], n_q[1]),
					sat_add(acc_rdata_q[AB-1:0], n_q[2])};
			end
			vna_pkg::ST_RD_WAIT: acc_addr = AW'(idx_q);
			vna_pkg::ST_SUM:     ;
			vna_pkg::ST_DIV_START: dv_start = 1'b1;
			default: ;
		endcase
		if (state_q == vna_pkg::ST_SUM) sq_start = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (pos_we)
			pos_mem[AW'(cmd_in.vertex_index)] <= {cmd_in.pos_x, cmd_in.pos_y, cmd_in.pos_z};
		pos_rdata_q <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (acc_we)
			acc_mem[acc_addr] <= acc_wdata;
		acc_rdata_q <= acc_mem[acc_addr];
	end

	assign mx = (m_q[0] >= m_q[1]) ? ((m_q[0] >= m_q[2]) ? m_q[0] : m_q[2])
		: ((m_q[1] >= m_q[2]) ? m_q[1] : m_q[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= vna_pkg::ST_IDLE;
			clr_q    <= '0;
			k_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_busy) clr_q <= clr_q + 1'b1;
			if (state_q == vna_pkg::ST_OUT) ovalid_q <= 1'b1;
			else if (nrm_out.valid && nrm_out.ready) ovalid_q <= 1'b0;
			unique case (state_q)
				vna_pkg::ST_IDLE:     k_q <= '0;
				vna_pkg::ST_TRI_WAIT: k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 1'b1;
				vna_pkg::ST_ACC_WR:   k_q <= k_q + 1'b1;
				vna_pkg::ST_DIV_NEXT: k_q <= k_q + 1'b1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= cmd_in.vertex_index;
			ca_q  <= cmd_in.corner_a;
			cb_q  <= cmd_in.corner_b;
			cc_q  <= cmd_in.corner_c;
			deg_q <= 1'b1;
			for (int i = 0; i < 3; i++) res_q[i] <= '0;
		end
		if (state_q == vna_pkg::ST_TRI_WAIT) begin
			if (k_q == 2'd0) begin
				pa_q[0] <= pos_rdata_q[3*PW-1 -: PW];
				pa_q[1] <= pos_rdata_q[2*PW-1 -: PW];
				pa_q[2] <= pos_rdata_q[PW-1:0];
			end else if (k_q == 2'd1) begin
				pb_q[0] <= pos_rdata_q[3*PW-1 -: PW];
				pb_q[1] <= pos_rdata_q[2*PW-1 -: PW];
				pb_q[2] <= pos_rdata_q[PW-1:0];
			end else begin
				for (int i = 0; i < 3; i++) begin
					e1_q[i] <= EW'(pb_q[i]) - EW'(pa_q[i]);
				end
				e2_q[0] <= EW'($signed(pos_rdata_q[3*PW-1 -: PW])) - EW'(pa_q[0]);
				e2_q[1] <= EW'($signed(pos_rdata_q[2*PW-1 -: PW])) - EW'(pa_q[1]);
				e2_q[2] <= EW'($signed(pos_rdata_q[PW-1:0])) - EW'(pa_q[2]);
			end
		end
		if (state_q == vna_pkg::ST_MUL) begin
			pr_q[0] <= e1_q[1] * e2_q[2];
			pr_q[1] <= e1_q[2] * e2_q[1];
			pr_q[2] <= e1_q[2] * e2_q[0];
			pr_q[3] <= e1_q[0] * e2_q[2];
			pr_q[4] <= e1_q[0] * e2_q[1];
			pr_q[5] <= e1_q[1] * e2_q[0];
		end
		if (state_q == vna_pkg::ST_CROSS) begin
			n_q[0] <= CW'(pr_q[0]) - CW'(pr_q[1]);
			n_q[1] <= CW'(pr_q[2]) - CW'(pr_q[3]);
			n_q[2] <= CW'(pr_q[4]) - CW'(pr_q[5]);
		end
		if (state_q == vna_pkg::ST_RD_MAG) begin
			a_q[0] <= acc_rdata_q[3*AB-1 -: AB];
			a_q[1] <= acc_rdata_q[2*AB-1 -: AB];
			a_q[2] <= acc_rdata_q[AB-1:0];
			m_q[0] <= magn(acc_rdata_q[3*AB-1 -: AB]);
			m_q[1] <= magn(acc_rdata_q[2*AB-1 -: AB]);
			m_q[2] <= magn(acc_rdata_q[AB-1:0]);
			s_q    <= '0;
		end
		// advance the shift one step a cycle until the peak fits
		if (state_q == vna_pkg::ST_SHIFT && mx != '0) begin
			if ((mx >> s_q) < (AB'(1) << LIM)) begin
				for (int i = 0; i < 3; i++) b_q[i] <= LIM'(m_q[i] >> s_q);
			end else begin
				s_q <= s_q + 1'b1;
			end
		end
		if (state_q == vna_pkg::ST_SQ) begin
			for (int i = 0; i < 3; i++) sq_q[i] <= b_q[i] * b_q[i];
		end
		if (state_q == vna_pkg::ST_SQRT && sq_done)
			len_q <= sq_root;
		if (state_q == vna_pkg::ST_DIV && dv_done) begin
			// quotient never exceeds 16384
			res_q[k_q] <= a_q[k_q][AB-1] ? (vna_pkg::NRM_W'(0) - vna_pkg::NRM_W'(dv_quo))
				: vna_pkg::NRM_W'(dv_quo);
			deg_q <= 1'b0;
		end
	end

	// sum of squares goes straight into the root unit when it starts
	assign sum_sq = SUMW'(sq_q[0]) + SUMW'(sq_q[1]) + SUMW'(sq_q[2]);

	assign dv_num = (NUMW'(b_q[k_q]) << 14) + NUMW'(len_q >> 1);

	vna_isqrt #(.IN_W(SUMW)) u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sum_sq),
		.done(sq_done), .root(sq_root)
	);

	vna_div #(.NUM_W(NUMW), .DEN_W(RW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num), .den(len_q),
		.done(dv_done), .quo(dv_quo)
	);

	assign nrm_out.valid      = ovalid_q;
	assign nrm_out.out_index  = idx_q;
	assign nrm_out.normal_x   = res_q[0];
	assign nrm_out.normal_y   = res_q[1];
	assign nrm_out.normal_z   = res_q[2];
	assign nrm_out.degenerate = deg_q;
endmodule

// ----- rtl/vna_checker.sv -----
// Port-level checks for the vertex normal accumulator, bound to the top level.
module vna_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic degenerate,
	input logic signed [15:0] normal_x,
	input logic signed [15:0] normal_y,
	input logic signed [15:0] normal_z
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("normal beat dropped while stalled");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
		else $error("degenerate beat carries nonzero components");

	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("command taken while a result is pending");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x <= 16384 && normal_x >= -16384
			&& normal_y <= 16384 && normal_y >= -16384
			&& normal_z <= 16384 && normal_z >= -16384)
		else $error("normal component out of unit range");
endmodule

bind vertex_normal_accumulator_top vna_checker u_vna_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(cmd_in.valid), .in_ready(cmd_in.ready),
	.out_valid(nrm_out.valid), .out_ready(nrm_out.ready),
	.degenerate(nrm_out.degenerate),
	.normal_x(nrm_out.normal_x), .normal_y(nrm_out.normal_y), .normal_z(nrm_out.normal_z)
);

// ----- verif/tb_vertex_normal_accumulator_top.sv -----
// Self-checking testbench for the vertex normal accumulator top level.
`timescale 1ns / 100ps

module tb_vertex_normal_accumulator_top;

	localparam int NV = 1024;
	localparam int IW = vna_pkg::IDX_W;
	localparam int PW = vna_pkg::POS_W;
	localparam int NW = vna_pkg::NRM_W;
	localparam longint ACC_HI = (64'sd1 <<< (vna_pkg::ACCUM_BITS_DEF - 1)) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam int QUIET_LIMIT = 5000;
	localparam int LATE_TAIL = 150;

	typedef struct {
		vna_pkg::cmd_t cmd;
		logic [IW-1:0] vidx;
		logic signed [PW-1:0] px, py, pz;
		logic [IW-1:0] ca, cb, cc;
		bit drain;
	} cmd_beat_t;

	typedef struct {
		logic [IW-1:0] vidx;
		logic signed [NW-1:0] nx, ny, nz;
		logic degen;
	} nrm_beat_t;

	logic clk, arst_n;
	vna_cmd_if cmd_ch();
	vna_nrm_if nrm_ch();

	vertex_normal_accumulator_top u_dut (
		.clk(clk), .arst_n(arst_n), .cmd_in(cmd_ch.sink), .nrm_out(nrm_ch.source));

	cmd_beat_t pending_cmds[$];
	nrm_beat_t expected_normals[$];
	cmd_beat_t cur;

	// predictor state
	logic signed [PW-1:0] vpos[NV][3];
	longint acc_x[NV], acc_y[NV], acc_z[NV];

	// generator bookkeeping
	bit loaded[NV];
	int loaded_list[$];
	int pool[$];

	int n_items, n_accepted, mismatches, quiet;
	int send_gap, recv_gap;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint sat_add(longint a, longint n);
		if (n > 0 && a > ACC_HI - n) return ACC_HI;
		if (n < 0 && a < ACC_LO - n) return ACC_LO;
		return a + n;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic nrm_beat_t unit_normal(int v);
		nrm_beat_t o;
		longint a[3];
		longint unsigned m[3], mx, sum, len, r;
		int s;
		o.vidx = v[IW-1:0];
		o.nx = '0; o.ny = '0; o.nz = '0; o.degen = 1'b1;
		a[0] = acc_x[v]; a[1] = acc_y[v]; a[2] = acc_z[v];
		mx = 0;
		for (int k = 0; k < 3; k++) begin
			m[k] = a[k] < 0 ? -a[k] : a[k];
			if (m[k] > mx) mx = m[k];
		end
		if (mx == 0) return o;
		s = 0;
		while ((mx >> s) >= (64'd1 << vna_pkg::NORM_LIM)) s++;
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			m[k] >>= s;
			sum += m[k] * m[k];
		end
		len = isqrt(sum);
		for (int k = 0; k < 3; k++) begin
			r = (m[k] * 16384 + len / 2) / len;
			if (a[k] < 0) r = -r;
			if (k == 0) o.nx = r[15:0];
			else if (k == 1) o.ny = r[15:0];
			else o.nz = r[15:0];
		end
		o.degen = 1'b0;
		return o;
	endfunction

	function automatic void predict_beat(cmd_beat_t b);
		longint e1[3], e2[3], n[3];
		int c[3];
		case (b.cmd)
			vna_pkg::CMD_LOAD: begin
				vpos[b.vidx][0] = b.px; vpos[b.vidx][1] = b.py; vpos[b.vidx][2] = b.pz;
				acc_x[b.vidx] = 0; acc_y[b.vidx] = 0; acc_z[b.vidx] = 0;
			end
			vna_pkg::CMD_TRI: begin
				c[0] = int'(b.ca); c[1] = int'(b.cb); c[2] = int'(b.cc);
				for (int k = 0; k < 3; k++) begin
					e1[k] = longint'(vpos[c[1]][k]) - longint'(vpos[c[0]][k]);
					e2[k] = longint'(vpos[c[2]][k]) - longint'(vpos[c[0]][k]);
				end
				n[0] = e1[1] * e2[2] - e1[2] * e2[1];
				n[1] = e1[2] * e2[0] - e1[0] * e2[2];
				n[2] = e1[0] * e2[1] - e1[1] * e2[0];
				// a repeated corner gets the product once per appearance
				for (int j = 0; j < 3; j++) begin
					acc_x[c[j]] = sat_add(acc_x[c[j]], n[0]);
					acc_y[c[j]] = sat_add(acc_y[c[j]], n[1]);
					acc_z[c[j]] = sat_add(acc_z[c[j]], n[2]);
				end
			end
			vna_pkg::CMD_READ: expected_normals.push_back(unit_normal(int'(b.vidx)));
			default: ;
		endcase
	endfunction

	function automatic cmd_beat_t noise_beat(vna_pkg::cmd_t c);
		cmd_beat_t b;
		b.cmd = c;
		b.vidx = IW'($urandom);
		b.px = PW'($urandom); b.py = PW'($urandom); b.pz = PW'($urandom);
		b.ca = IW'($urandom); b.cb = IW'($urandom); b.cc = IW'($urandom);
		b.drain = 1'b0;
		return b;
	endfunction

	task automatic push_load(int v, logic signed [15:0] x, y, z);
		cmd_beat_t b;
		b = noise_beat(vna_pkg::CMD_LOAD);
		b.vidx = IW'(v); b.px = x; b.py = y; b.pz = z;
		if (!loaded[v]) loaded_list.push_back(v);
		loaded[v] = 1'b1;
		pending_cmds.push_back(b);
	endtask

	task automatic push_tri(int a, int b2, int c);
		cmd_beat_t b;
		b = noise_beat(vna_pkg::CMD_TRI);
		b.ca = IW'(a); b.cb = IW'(b2); b.cc = IW'(c);
		pending_cmds.push_back(b);
	endtask

	task automatic push_read(int v, bit drain);
		cmd_beat_t b;
		b = noise_beat(vna_pkg::CMD_READ);
		b.vidx = IW'(v); b.drain = drain;
		pending_cmds.push_back(b);
	endtask

	function automatic int pick_loaded();
		return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
	endfunction

	// stimulus and end of run
	initial begin
		int sel;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd = vna_pkg::CMD_NONE;
		cmd_ch.vertex_index = '0;
		cmd_ch.pos_x = '0; cmd_ch.pos_y = '0; cmd_ch.pos_z = '0;
		cmd_ch.corner_a = '0; cmd_ch.corner_b = '0; cmd_ch.corner_c = '0;
		nrm_ch.ready = 1'b0;
		arst_n = 1'b0;
		for (int i = 0; i < NV; i++) begin
			vpos[i][0] = 0; vpos[i][1] = 0; vpos[i][2] = 0;
			acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
			loaded[i] = 1'b0;
		end

		// directed: extreme positions, every command, repeated corners
		push_load(0, 16'sh8000, 16'sh8000, 16'sh8000);
		push_load(1, 16'sh7fff, 16'sh8000, 16'sh0000);
		push_load(1023, 16'sh8000, 16'sh7fff, 16'sh7fff);
		push_load(682, 16'sh0100, 16'sh0000, 16'sh0000);
		push_load(341, 16'sh0000, 16'sh0100, 16'sh0000);
		push_tri(0, 1, 1023);
		push_read(0, 1'b0);
		push_read(1, 1'b0);
		push_read(1023, 1'b0);
		push_tri(1023, 682, 341);
		push_tri(682, 682, 341);
		push_tri(341, 341, 341);
		push_read(682, 1'b0);
		push_read(341, 1'b0);
		push_read(512, 1'b0);
		pending_cmds.push_back(noise_beat(vna_pkg::CMD_NONE));
		push_load(0, 16'sh0000, 16'sh0000, 16'sh0000);
		push_read(0, 1'b1);
		push_tri(0, 1, 1023);
		push_read(0, 1'b0);

		for (int i = 0; i < 48; i++) pool.push_back($urandom_range(0, NV - 1));
		pool.push_back(0);
		pool.push_back(NV - 1);
		for (int i = 0; i < 1750; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 4)
				pending_cmds.push_back(noise_beat(vna_pkg::CMD_NONE));
			else if (sel < 28 || loaded_list.size() < 3)
				push_load(pool[$urandom_range(0, pool.size() - 1)], PW'($urandom),
					PW'($urandom), PW'($urandom));
			else if (sel < 72) begin
				if (sel < 30) push_tri(pick_loaded(), pick_loaded(), loaded_list[0]);
				else push_tri(pick_loaded(), pick_loaded(), pick_loaded());
			end else if (sel < 92)
				push_read(pool[$urandom_range(0, pool.size() - 1)], i == 900);
			else
				push_read($urandom_range(0, NV - 1), 1'b0);
		end
		n_items = pending_cmds.size();

		// predictor starts over from reset values
		for (int i = 0; i < NV; i++) begin
			vpos[i][0] = 0; vpos[i][1] = 0; vpos[i][2] = 0;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait (n_accepted == n_items && expected_normals.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_normals.size() == 0)
			$display("vertex_normal_accumulator_top verification clean");
		else
			$display("vertex_normal_accumulator_top verification failed");
		$finish;
	end

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			send_gap = 0;
			n_accepted = 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				predict_beat(cur);
				n_accepted++;
			end
			if (cmd_ch.valid && !cmd_ch.ready) begin
				// hold the beat
			end else if (send_gap > 0) begin
				send_gap--;
				cmd_ch.valid <= 1'b0;
			end else if (n_accepted < n_items - LATE_TAIL && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(1, 17);
				cmd_ch.valid <= 1'b0;
			end else if (pending_cmds.size() > 0 &&
					(!pending_cmds[0].drain || expected_normals.size() == 0)) begin
				cur = pending_cmds.pop_front();
				cmd_ch.valid <= 1'b1;
				cmd_ch.cmd <= cur.cmd;
				cmd_ch.vertex_index <= cur.vidx;
				cmd_ch.pos_x <= cur.px;
				cmd_ch.pos_y <= cur.py;
				cmd_ch.pos_z <= cur.pz;
				cmd_ch.corner_a <= cur.ca;
				cmd_ch.corner_b <= cur.cb;
				cmd_ch.corner_c <= cur.cc;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// normal receiver and checker
	always @(posedge clk or negedge arst_n) begin
		nrm_beat_t exp_n;
		if (!arst_n) begin
			nrm_ch.ready <= 1'b0;
			recv_gap = 0;
			mismatches = 0;
		end else begin
			if (nrm_ch.valid && nrm_ch.ready) begin
				if (expected_normals.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected normal beat for vertex %0d", nrm_ch.out_index);
				end else begin
					exp_n = expected_normals.pop_front();
					if (nrm_ch.out_index !== exp_n.vidx || nrm_ch.normal_x !== exp_n.nx ||
							nrm_ch.normal_y !== exp_n.ny || nrm_ch.normal_z !== exp_n.nz ||
							nrm_ch.degenerate !== exp_n.degen) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"normal mismatch: exp v%0d (%0d,%0d,%0d) d%0b",
								" got v%0d (%0d,%0d,%0d) d%0b"},
								exp_n.vidx, exp_n.nx, exp_n.ny, exp_n.nz, exp_n.degen,
								nrm_ch.out_index, nrm_ch.normal_x, nrm_ch.normal_y,
								nrm_ch.normal_z, nrm_ch.degenerate);
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				nrm_ch.ready <= 1'b0;
			end else if (n_accepted < n_items - LATE_TAIL && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(1, 17);
				nrm_ch.ready <= 1'b0;
			end else begin
				nrm_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog: count cycles with no beat on either channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet <= 0;
		end else if ((cmd_ch.valid && cmd_ch.ready) || (nrm_ch.valid && nrm_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("vertex_normal_accumulator_top verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

endmodule
